// ----- rtl/core/pointer_accel_custom_curve_top_assert.svh -----
// assertion helpers for the pointer acceleration block
`ifndef POINTER_ACCEL_CUSTOM_CURVE_TOP_ASSERT_SVH
`define POINTER_ACCEL_CUSTOM_CURVE_TOP_ASSERT_SVH

// check sampled on the rising clock, off while reset is high
`define PACC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check sampled on the rising clock, also active during reset
`define PACC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- rtl/core/pacc_pkg.sv -----
// ----------------------------------------------------------------------------
// pacc_pkg
// Shared constants for the pointer acceleration block: curve store size,
// command codes, register indexes and arithmetic limits.
// ----------------------------------------------------------------------------
package pacc_pkg;

   // curve store
   localparam int MAX_POINTS = 64;
   localparam int PTR_W      = $clog2(MAX_POINTS);

   // timing constants in milliseconds
   localparam logic [31:0] TIMEOUT_MS        = 32'd1000;
   localparam logic [9:0]  FIRST_INTERVAL_MS = 10'd7;

   // largest |intercept| * interval for the direct intercept branch
   localparam logic [63:0] ICEPT_LIMIT = 64'd2097151;

   // shared divider size
   localparam int DIV_NUM_W = 42;
   localparam int DIV_DEN_W = 33;

   // root and fraction step counts
   localparam int SQRT_STEPS = 32;
   localparam int FRAC_STEPS = 20;

   // command codes
   localparam logic CMD_MOTION = 1'b0;
   localparam logic CMD_WRITE  = 1'b1;

   // register indexes
   localparam logic [1:0] REG_DELTA_SCALE = 2'd0;
   localparam logic [1:0] REG_SPEED_STEP  = 2'd1;
   localparam logic [1:0] REG_POINT_COUNT = 2'd2;

endpackage

// ----- rtl/core/pointer_accel_custom_curve_top.sv -----
// ----------------------------------------------------------------------------
// pointer_accel_custom_curve_top
// Pointer acceleration with a stored speed curve, Q10 gain on each delta.
// ----------------------------------------------------------------------------
// One word in, at most one word out. A table write gives no result; a
// zero-motion event gives (0,0) and skips the arithmetic. A motion event
// runs through one shared sequencer: a 32-step integer square root, four
// passes of a 42-step restoring divider, a 20-step fraction loop on the split
// intercept branch and a shared 32x32 multiplier. The curve lives in a
// synchronous memory read twice per event. Only one word is in flight; a
// finished result waits in the output register while the next word is taken.
module pointer_accel_custom_curve_top (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic signed [15:0] req_delta_x,
   input  logic signed [15:0] req_delta_y,
   input  logic [31:0]        req_stamp_ms,
   input  logic [5:0]         req_point_index,
   input  logic signed [31:0] req_point_value,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_x_q10,
   output logic signed [31:0] rsp_y_q10,
   // register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int PW = pacc_pkg::PTR_W;
   localparam int NW = pacc_pkg::DIV_NUM_W;
   localparam int DW = pacc_pkg::DIV_DEN_W;

   typedef enum logic [4:0] {
      S_IDLE, S_SQX, S_SQY, S_SQADD, S_SQRT, S_DIST, S_DIV, S_SPEED, S_INDEX,
      S_RD0, S_RD1, S_RD2, S_SLOPE, S_ICEPT, S_SGAIN, S_ICHK, S_IC1, S_IC2,
      S_WMUL, S_FRAC, S_FMUL, S_FADD, S_GAIN, S_OX, S_OY, S_OUT
   } state_type;

   state_type state_ff, div_ret_ff;

   // configuration and event history
   logic [15:0] delta_scale_ff, speed_step_ff;
   logic [6:0]  point_count_ff;
   logic [31:0] prev_stamp_ff;
   logic [9:0]  prev_interval_ff;

   // event operands
   logic signed [15:0] dx_ff, dy_ff;
   logic [9:0]  dt_ff;
   logic [30:0] mx_ff, my_ff;
   logic [31:0] dist_ff;
   logic [PW-1:0] idx_ff;
   logic [31:0] y0_ff, slope_ff, icept_ff;
   logic [31:0] sgain_ff, igain_ff, gain_ff, whole_ff, rwhole_ff, ox_ff;
   logic        ineg_ff, out_zero_ff;

   // root
   logic [63:0] sq_v_ff, sq_r_ff, sq_bit_ff;

   // divider
   logic [NW-1:0] div_num_ff;
   logic [DW-1:0] div_den_ff;
   logic [DW:0]   div_rem_ff;
   logic [5:0]    iter_cnt_ff;

   // fraction loop
   logic [31:0] fnum_ff;
   logic [19:0] fres_ff;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic        mul_en;
   logic [63:0] prod_ff;

   // output register
   logic        rsp_valid_ff;
   logic [31:0] rsp_x_ff, rsp_y_ff;

   // curve memory
   logic [31:0]   curve_mem [pacc_pkg::MAX_POINTS];
   logic [31:0]   rdata_ff;
   logic [PW-1:0] rd_addr;

   // request decode and interval
   logic        req_take;
   logic [31:0] dt_raw;
   logic [9:0]  dt_new;
   logic [15:0] adx, ady;

   // derived values
   logic [15:0]   step_eff;
   logic [31:0]   cnt_eff, idx_lim;
   logic [DW-1:0] dmag;
   logic [31:0]   slope_mag, icept_mag;
   logic [DW:0]   div_t;
   logic          div_ge;
   logic [63:0]   sq_sum;
   logic [31:0]   fn_sh;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign pready    = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_x_q10 = rsp_x_ff;
   assign rsp_y_q10 = rsp_y_ff;

   // interval since the last event; previous interval if the stamp did not advance, first interval on timeout
   always_comb begin
      dt_raw = (req_stamp_ms > prev_stamp_ff) ? (req_stamp_ms - prev_stamp_ff)
                                              : {22'd0, prev_interval_ff};
      if (dt_raw > pacc_pkg::TIMEOUT_MS || dt_raw == 32'd0) begin
         dt_new = pacc_pkg::FIRST_INTERVAL_MS;
      end else begin
         dt_new = dt_raw[9:0];
      end
   end

   assign adx = req_delta_x[15] ? 16'(-req_delta_x) : req_delta_x;
   assign ady = req_delta_y[15] ? 16'(-req_delta_y) : req_delta_y;

   // clamped step, point count and index limit
   assign step_eff = (speed_step_ff == 16'd0) ? 16'd1 : speed_step_ff;
   always_comb begin
      if (point_count_ff < 7'd2) begin
         cnt_eff = 32'd2;
      end else if (32'(point_count_ff) > 32'(pacc_pkg::MAX_POINTS)) begin
         cnt_eff = 32'(pacc_pkg::MAX_POINTS);
      end else begin
         cnt_eff = 32'(point_count_ff);
      end
   end
   assign idx_lim = cnt_eff - 32'd2;

   // magnitudes of the signed operands
   assign dmag      = dist_ff[31] ? (DW'(33'h1_0000_0000) - DW'(dist_ff)) : DW'(dist_ff);
   assign slope_mag = slope_ff[31] ? (32'd0 - slope_ff) : slope_ff;
   assign icept_mag = icept_ff[31] ? (32'd0 - icept_ff) : icept_ff;

   // one restoring divider step
   assign div_t  = {div_rem_ff[DW-1:0], div_num_ff[NW-1]};
   assign div_ge = (div_t >= {1'b0, div_den_ff});

   // one root step
   assign sq_sum = sq_r_ff + sq_bit_ff;

   // one fraction step
   assign fn_sh = {fnum_ff[30:0], 1'b0};

   // multiplier operand select
   always_comb begin
      mul_en = 1'b1;
      mul_a  = 32'd0;
      mul_b  = 32'd0;
      case (state_ff)
         S_SQX:   begin mul_a = {1'b0, mx_ff}; mul_b = {1'b0, mx_ff}; end
         S_SQY:   begin mul_a = {1'b0, my_ff}; mul_b = {1'b0, my_ff}; end
         S_SLOPE: begin mul_a = 32'(idx_ff); mul_b = slope_ff; end
         S_SGAIN: begin mul_a = icept_mag; mul_b = {22'd0, dt_ff}; end
         S_WMUL:  begin mul_a = whole_ff; mul_b = {22'd0, dt_ff}; end
         S_FMUL:  begin mul_a = {12'd0, fres_ff}; mul_b = {22'd0, dt_ff}; end
         S_OX:    begin mul_a = 32'(dx_ff); mul_b = gain_ff; end
         S_OY:    begin mul_a = 32'(dy_ff); mul_b = gain_ff; end
         default: mul_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= 64'(mul_a) * 64'(mul_b);
      end
   end

   // curve memory: write on table command, one read per cycle
   assign rd_addr = (state_ff == S_RD1) ? (idx_ff + PW'(1)) : idx_ff;

   always_ff @(posedge clock) begin
      if (req_take && req_command == pacc_pkg::CMD_WRITE &&
          32'(req_point_index) < 32'(pacc_pkg::MAX_POINTS)) begin
         curve_mem[PW'(req_point_index)] <= req_point_value;
      end
      rdata_ff <= curve_mem[rd_addr];
   end

   // register read
   always_comb begin
      unique case (paddr[3:2])
         pacc_pkg::REG_DELTA_SCALE: prdata = {16'd0, delta_scale_ff};
         pacc_pkg::REG_SPEED_STEP:  prdata = {16'd0, speed_step_ff};
         pacc_pkg::REG_POINT_COUNT: prdata = {25'd0, point_count_ff};
         default:                   prdata = 32'd0;
      endcase
   end

   // register write
   always_ff @(posedge clock) begin
      if (reset) begin
         delta_scale_ff <= 16'd1;
         speed_step_ff  <= 16'd1;
         point_count_ff <= 7'd2;
      end else if (psel && penable && pwrite && pready) begin
         unique case (paddr[3:2])
            pacc_pkg::REG_DELTA_SCALE: delta_scale_ff <= pwdata[15:0];
            pacc_pkg::REG_SPEED_STEP:  speed_step_ff  <= pwdata[15:0];
            pacc_pkg::REG_POINT_COUNT: point_count_ff <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         div_ret_ff       <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         prev_stamp_ff    <= 32'd0;
         prev_interval_ff <= pacc_pkg::FIRST_INTERVAL_MS;
      end else begin
         // result taken, the output state reloads it itself
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_take && req_command == pacc_pkg::CMD_MOTION) begin
                  dx_ff <= req_delta_x;
                  dy_ff <= req_delta_y;
                  if (req_delta_x == 16'sd0 && req_delta_y == 16'sd0) begin
                     out_zero_ff <= 1'b1;
                     state_ff    <= S_OUT;
                  end else begin
                     out_zero_ff      <= 1'b0;
                     dt_ff            <= dt_new;
                     prev_stamp_ff    <= req_stamp_ms;
                     prev_interval_ff <= dt_new;
                     mx_ff            <= 31'(32'(adx) * 32'(delta_scale_ff));
                     my_ff            <= 31'(32'(ady) * 32'(delta_scale_ff));
                     state_ff         <= S_SQX;
                  end
               end
            end
            S_SQX: state_ff <= S_SQY;
            S_SQY: begin
               sq_v_ff  <= prod_ff;
               state_ff <= S_SQADD;
            end
            S_SQADD: begin
               sq_v_ff     <= sq_v_ff + prod_ff;
               sq_r_ff     <= 64'd0;
               sq_bit_ff   <= 64'd1 << 62;
               iter_cnt_ff <= 6'(pacc_pkg::SQRT_STEPS - 1);
               state_ff    <= S_SQRT;
            end
            S_SQRT: begin
               if (sq_v_ff >= sq_sum) begin
                  sq_v_ff <= sq_v_ff - sq_sum;
                  sq_r_ff <= (sq_r_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_r_ff <= sq_r_ff >> 1;
               end
               sq_bit_ff   <= sq_bit_ff >> 2;
               iter_cnt_ff <= iter_cnt_ff - 6'd1;
               if (iter_cnt_ff == 6'd0) begin
                  state_ff <= S_DIST;
               end
            end
            S_DIST: begin
               dist_ff <= sq_r_ff[31:0];
               if (sq_r_ff[31:0] == 32'd0) begin
                  out_zero_ff <= 1'b1;
                  state_ff    <= S_OUT;
               end else begin
                  // speed = distance / interval
                  div_num_ff  <= NW'(sq_r_ff[31:0]);
                  div_den_ff  <= DW'(dt_ff);
                  div_rem_ff  <= '0;
                  iter_cnt_ff <= 6'(NW - 1);
                  div_ret_ff  <= S_SPEED;
                  state_ff    <= S_DIV;
               end
            end
            S_DIV: begin
               div_rem_ff  <= div_ge ? (div_t - {1'b0, div_den_ff}) : div_t;
               div_num_ff  <= {div_num_ff[NW-2:0], div_ge};
               iter_cnt_ff <= iter_cnt_ff - 6'd1;
               if (iter_cnt_ff == 6'd0) begin
                  state_ff <= div_ret_ff;
               end
            end
            S_SPEED: begin
               // index = speed / step
               div_num_ff  <= NW'(div_num_ff[31:0]);
               div_den_ff  <= DW'(step_eff);
               div_rem_ff  <= '0;
               iter_cnt_ff <= 6'(NW - 1);
               div_ret_ff  <= S_INDEX;
               state_ff    <= S_DIV;
            end
            S_INDEX: begin
               if (div_num_ff > NW'(idx_lim)) begin
                  idx_ff <= PW'(idx_lim);
               end else begin
                  idx_ff <= PW'(div_num_ff);
               end
               state_ff <= S_RD0;
            end
            S_RD0: state_ff <= S_RD1;
            S_RD1: begin
               y0_ff    <= rdata_ff;
               state_ff <= S_RD2;
            end
            S_RD2: begin
               slope_ff <= rdata_ff - y0_ff;
               state_ff <= S_SLOPE;
            end
            S_SLOPE: state_ff <= S_ICEPT;
            S_ICEPT: begin
               icept_ff    <= y0_ff - prod_ff[31:0];
               // slope gain = slope * 1024 / step
               div_num_ff  <= NW'(slope_mag) << 10;
               div_den_ff  <= DW'(step_eff);
               div_rem_ff  <= '0;
               iter_cnt_ff <= 6'(NW - 1);
               div_ret_ff  <= S_SGAIN;
               state_ff    <= S_DIV;
            end
            S_SGAIN: begin
               sgain_ff <= slope_ff[31] ? (32'd0 - div_num_ff[31:0]) : div_num_ff[31:0];
               state_ff <= S_ICHK;
            end
            S_ICHK: begin
               ineg_ff     <= icept_ff[31] ^ dist_ff[31];
               div_den_ff  <= dmag;
               div_rem_ff  <= '0;
               iter_cnt_ff <= 6'(NW - 1);
               state_ff    <= S_DIV;
               if (prod_ff <= pacc_pkg::ICEPT_LIMIT) begin
                  // direct branch: |icept| * interval * 1024 / |distance|
                  div_num_ff <= NW'(prod_ff[31:0]) << 10;
                  div_ret_ff <= S_IC1;
               end else begin
                  // split branch: whole part and remainder
                  div_num_ff <= NW'(icept_mag);
                  div_ret_ff <= S_IC2;
               end
            end
            S_IC1: begin
               igain_ff <= ineg_ff ? (32'd0 - div_num_ff[31:0]) : div_num_ff[31:0];
               state_ff <= S_GAIN;
            end
            S_IC2: begin
               whole_ff <= ineg_ff ? (32'd0 - div_num_ff[31:0]) : div_num_ff[31:0];
               fnum_ff  <= div_rem_ff[31:0];
               state_ff <= S_WMUL;
            end
            S_WMUL: begin
               fres_ff     <= 20'd0;
               iter_cnt_ff <= 6'(pacc_pkg::FRAC_STEPS - 1);
               state_ff    <= S_FRAC;
            end
            S_FRAC: begin
               rwhole_ff <= {prod_ff[21:0], 10'd0};
               if (fn_sh >= dist_ff) begin
                  fnum_ff <= fn_sh - dist_ff;
                  fres_ff <= {fres_ff[18:0], 1'b1};
               end else begin
                  fnum_ff <= fn_sh;
                  fres_ff <= {fres_ff[18:0], 1'b0};
               end
               iter_cnt_ff <= iter_cnt_ff - 6'd1;
               if (iter_cnt_ff == 6'd0) begin
                  state_ff <= S_FMUL;
               end
            end
            S_FMUL: state_ff <= S_FADD;
            S_FADD: begin
               igain_ff <= icept_ff[31] ? (rwhole_ff - prod_ff[41:10])
                                        : (rwhole_ff + prod_ff[41:10]);
               state_ff <= S_GAIN;
            end
            S_GAIN: begin
               gain_ff  <= sgain_ff + igain_ff;
               state_ff <= S_OX;
            end
            S_OX: state_ff <= S_OY;
            S_OY: begin
               ox_ff    <= prod_ff[31:0];
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_x_ff     <= out_zero_ff ? 32'd0 : ox_ff;
                  rsp_y_ff     <= out_zero_ff ? 32'd0 : prod_ff[31:0];
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`include "pointer_accel_custom_curve_top_assert.svh"

   // a nonzero motion word always starts the sequencer
   `PACC_ASSERT(a_motion_busy, (req_take && req_command == pacc_pkg::CMD_MOTION && (req_delta_x != 16'sd0 || req_delta_y != 16'sd0)) |=> (state_ff == S_SQX), "motion word did not start the sequencer")

   // the divider never runs with a zero divisor
   `PACC_ASSERT(a_div_nonzero, (state_ff == S_DIV) |-> (div_den_ff != '0), "divider started with zero divisor")

   // curve index stays inside the clamped point count
   `PACC_ASSERT(a_idx_range, (state_ff == S_RD0) |-> (32'(idx_ff) <= idx_lim), "curve index beyond point count")

   // a new result only comes out of the output state
   `PACC_ASSERT(a_rsp_source, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT), "result raised outside output state")

   // stored interval is always a usable divisor
   `PACC_ASSERT_ALWAYS(a_interval_range, (!reset) |-> (prev_interval_ff != 10'd0 && 32'(prev_interval_ff) <= pacc_pkg::TIMEOUT_MS), "stored interval out of range")

endmodule
